// ===== hw/rtl/wnpc_pkg.sv =====
// shared types, constants and helpers for the weighted nearest palette color block
// used by wnpc_dist, wnpc_seq and weighted_nearest_palette_color
package wnpc_pkg;

  localparam int PALETTE_SIZE = 256;
  localparam int ADDR_W       = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam int CHAN_W       = 6;
  localparam int IN_W         = 10;
  localparam int IDX_W        = 8;
  localparam int DIST_W       = 9;
  localparam logic [CHAN_W-1:0] CHAN_MAX = CHAN_W'(63);

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } rgb_t;

  // a set bit doubles that channel's difference
  typedef struct packed {
    logic r;
    logic g;
    logic b;
  } weight_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  function automatic logic [CHAN_W-1:0] clamp_chan(input logic signed [IN_W-1:0] v);
    logic [CHAN_W-1:0] res;
    if (v[IN_W-1]) begin
      res = '0;
    end else if (v[IN_W-2:CHAN_W] != '0) begin
      res = CHAN_MAX;
    end else begin
      res = v[CHAN_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/weighted_nearest_palette_color.sv =====
// top level of the weighted nearest palette color search
// depends on wnpc_pkg and wnpc_seq; does query clamping and channel weighting
//
// usage:
//   input channel (in_valid / in_ready) carries kind, entry_index, red, green, blue.
//   a write beat (kind 0) stores the low 6 bits of each channel at entry_index
//   and gives no result; the next beat is taken right after.
//   a query beat (kind 1) clamps each channel to 0..63, doubles the weight of
//   the largest channel(s), and scans entries 1 to 255 one per cycle through a
//   single distance unit fed from the palette memory's registered read port.
//   output channel (out_valid / out_ready) returns best_index and best_distance.
//   out_valid rises after the SCAN reads, the DRAIN compare of the last read
//   and the output load in DONE; in_ready is low through all of these, so a
//   new query waits for the last one to finish while writes go back to back.
//   the output register holds a result until taken; writes are still accepted
//   meanwhile, and a following query finishes its scan and then waits for the
//   output register to free up before returning to idle.
//   reset clears the control state only; palette contents are undefined until
//   written, so load every entry that a query will reach first.
module weighted_nearest_palette_color (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  kind,
  input  logic [wnpc_pkg::IDX_W-1:0]            entry_index,
  input  logic signed [wnpc_pkg::IN_W-1:0]      red,
  input  logic signed [wnpc_pkg::IN_W-1:0]      green,
  input  logic signed [wnpc_pkg::IN_W-1:0]      blue,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [wnpc_pkg::IDX_W-1:0]            best_index,
  output logic [wnpc_pkg::DIST_W-1:0]           best_distance
);
  import wnpc_pkg::*;

  rgb_t    wr_color;
  rgb_t    q_color;
  weight_t q_weight;

  always_comb begin
    wr_color.r = red[CHAN_W-1:0];
    wr_color.g = green[CHAN_W-1:0];
    wr_color.b = blue[CHAN_W-1:0];
    q_color.r  = clamp_chan(red);
    q_color.g  = clamp_chan(green);
    q_color.b  = clamp_chan(blue);
    q_weight.r = (q_color.r >= q_color.g) && (q_color.r >= q_color.b);
    q_weight.g = (q_color.g >= q_color.r) && (q_color.g >= q_color.b);
    q_weight.b = (q_color.b >= q_color.r) && (q_color.b >= q_color.g);
  end

  wnpc_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .entry_index   (entry_index),
    .wr_color      (wr_color),
    .q_color       (q_color),
    .q_weight      (q_weight),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .best_index    (best_index),
    .best_distance (best_distance)
  );

endmodule

// ===== hw/rtl/wnpc_dist.sv =====
// weighted manhattan distance between a query color and one palette entry
// depends on wnpc_pkg
module wnpc_dist (
  input  wnpc_pkg::rgb_t                    query,
  input  wnpc_pkg::weight_t                 weight,
  input  wnpc_pkg::rgb_t                    entry,
  output logic [wnpc_pkg::DIST_W-1:0]       wdist
);
  import wnpc_pkg::*;

  logic [CHAN_W-1:0] dr, dg, db;

  always_comb begin
    dr = (entry.r > query.r) ? (entry.r - query.r) : (query.r - entry.r);
    dg = (entry.g > query.g) ? (entry.g - query.g) : (query.g - entry.g);
    db = (entry.b > query.b) ? (entry.b - query.b) : (query.b - entry.b);
    wdist = (DIST_W'(dr) << weight.r) + (DIST_W'(dg) << weight.g)
          + (DIST_W'(db) << weight.b);
  end

endmodule

// ===== hw/rtl/wnpc_seq.sv =====
// palette memory, scan sequencer, best-match tracking and output register
// depends on wnpc_pkg and wnpc_dist
module wnpc_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [wnpc_pkg::IDX_W-1:0]    entry_index,
  input  wnpc_pkg::rgb_t                wr_color,
  input  wnpc_pkg::rgb_t                q_color,
  input  wnpc_pkg::weight_t             q_weight,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wnpc_pkg::IDX_W-1:0]    best_index,
  output logic [wnpc_pkg::DIST_W-1:0]   best_distance
);
  import wnpc_pkg::*;

  localparam logic [ADDR_W-1:0] FIRST = ADDR_W'(1);
  localparam logic [ADDR_W-1:0] LAST  = ADDR_W'(PALETTE_SIZE - 1);

  rgb_t mem [PALETTE_SIZE];

  state_t            state;
  rgb_t              query;
  weight_t           weight;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_pend;
  logic [ADDR_W-1:0] pend_idx;
  rgb_t              rdata;
  logic              have;
  logic [ADDR_W-1:0] best_idx;
  logic [DIST_W-1:0] best_d;
  logic [DIST_W-1:0] wdist;
  logic              accept;
  logic              mem_we;
  logic              rd_en;
  logic              out_load;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign mem_we   = accept && (kind == KIND_WRITE)
                    && ({1'b0, entry_index} < (IDX_W + 1)'(PALETTE_SIZE));
  assign rd_en    = (state == ST_SCAN);
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[entry_index[ADDR_W-1:0]] <= wr_color;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  wnpc_dist u_dist (
    .query  (query),
    .weight (weight),
    .entry  (rdata),
    .wdist  (wdist)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_pend   <= 1'b0;
      have      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      rd_pend <= rd_en;
      if (rd_en) begin
        pend_idx <= rd_addr;
      end

      // lower index wins on a tie since entries arrive in order
      if (rd_pend && (!have || wdist < best_d)) begin
        have     <= 1'b1;
        best_idx <= pend_idx;
        best_d   <= wdist;
      end

      case (state)
        ST_IDLE: begin
          if (accept && kind == KIND_QUERY) begin
            query   <= q_color;
            weight  <= q_weight;
            rd_addr <= FIRST;
            have    <= 1'b0;
            state   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_addr == LAST) begin
            state <= ST_DRAIN;
          end else begin
            rd_addr <= rd_addr + ADDR_W'(1);
          end
        end
        ST_DRAIN: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            best_index    <= IDX_W'(best_idx);
            best_distance <= best_d;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
